// ===== rtl/hidkb_pkg.sv =====
// Package for the HID boot keyboard report builder.
// Holds the operation and status codes, the report constants, the US layout ROM
// and the decoded key type. It depends on nothing.
package hidkb_pkg;

   localparam int KEY_SLOTS             = 6;
   localparam int SLOT_MAX              = 6;
   localparam int ISO_KEY_USAGE         = 50;
   localparam int ISO_REPLACEMENT_USAGE = 100;

   localparam logic [7:0] RAW_USAGE_BASE = 8'd136;
   localparam logic [7:0] ALTGR_MOD      = 8'h40;
   localparam logic [7:0] SHIFT_MOD      = 8'h02;
   localparam logic [7:0] ALTGR_MASK     = 8'h3F;
   localparam logic [7:0] SHIFT_MASK     = 8'h7F;

   typedef enum logic [1:0] {
      OP_PRESS       = 2'd0,
      OP_RELEASE     = 2'd1,
      OP_RELEASE_ALL = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_SENT     = 2'd0,
      ST_UNMAPPED = 2'd1,
      ST_FULL     = 2'd2
   } status_type;

   typedef struct packed {
      logic       mapped;
      logic [7:0] usage;
      logic [7:0] mods;
   } key_decode_type;

   localparam logic [7:0] US_ROM [0:127] = '{
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h2a, 8'h2b, 8'h28, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h2c, 8'h9e, 8'hb4, 8'ha0, 8'ha1, 8'ha2, 8'ha4, 8'h34,
      8'ha6, 8'ha7, 8'ha5, 8'hae, 8'h36, 8'h2d, 8'h37, 8'h38,
      8'h27, 8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24,
      8'h25, 8'h26, 8'hb3, 8'h33, 8'hb6, 8'h2e, 8'hb7, 8'hb8,
      8'h9f, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8a,
      8'h8b, 8'h8c, 8'h8d, 8'h8e, 8'h8f, 8'h90, 8'h91, 8'h92,
      8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9a,
      8'h9b, 8'h9c, 8'h9d, 8'h2f, 8'h31, 8'h30, 8'ha3, 8'had,
      8'h35, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0a,
      8'h0b, 8'h0c, 8'h0d, 8'h0e, 8'h0f, 8'h10, 8'h11, 8'h12,
      8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1a,
      8'h1b, 8'h1c, 8'h1d, 8'haf, 8'hb1, 8'hb0, 8'hb5, 8'h00
   };

endpackage

// ===== rtl/hidkb_key_decoder.sv =====
// Key code decoder: turns an 8-bit key code into a usage and modifier bits.
// Depends on hidkb_pkg for the layout ROM and the decoded key type.
module hidkb_key_decoder (
   input  logic [7:0]                key_code,
   output hidkb_pkg::key_decode_type decoded
);
   import hidkb_pkg::*;

   logic [7:0] rom_entry;
   logic [7:0] print_usage;

   assign rom_entry = US_ROM[key_code[6:0]];

   always_comb begin
      decoded = '0;
      print_usage = rom_entry;
      if (key_code >= RAW_USAGE_BASE) begin
         decoded.mapped = 1'b1;
         decoded.usage  = key_code - RAW_USAGE_BASE;
      end else if (key_code[7]) begin
         decoded.mapped = 1'b1;
         decoded.mods   = 8'd1 << key_code[2:0];
      end else begin
         decoded.mapped = (rom_entry != 8'd0);
         if (rom_entry[7:6] == 2'b11) begin
            decoded.mods = ALTGR_MOD;
            print_usage  = rom_entry & ALTGR_MASK;
         end else if (rom_entry[7]) begin
            decoded.mods = SHIFT_MOD;
            print_usage  = rom_entry & SHIFT_MASK;
         end
         if (print_usage == 8'(ISO_KEY_USAGE)) begin
            print_usage = 8'(ISO_REPLACEMENT_USAGE);
         end
         decoded.usage = print_usage;
      end
   end

endmodule

// ===== rtl/hid_boot_keyboard_report_builder.sv =====
// Top level of the HID boot keyboard report builder (six-key rollover).
// Depends on hidkb_pkg and hidkb_key_decoder.
//
// Each key event item (press, release, release all) yields one result item
// carrying a status and the full boot report after the event. The block is a
// two-register pipeline: an input register, then an execute step that decodes
// the key, updates the held modifier byte and key slots and loads the result
// register. A result is registered once the execute step has handled its item,
// and one item is taken every cycle as long as results are taken; the result
// register lets the next item enter while a finished report still waits. The
// held report state is cleared by reset.
module hid_boot_keyboard_report_builder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_operation,
   input  logic [7:0] req_key_code,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_modifier_byte,
   output logic [7:0] rsp_slot_zero,
   output logic [7:0] rsp_slot_one,
   output logic [7:0] rsp_slot_two,
   output logic [7:0] rsp_slot_three,
   output logic [7:0] rsp_slot_four,
   output logic [7:0] rsp_slot_five
);
   import hidkb_pkg::*;

   logic           s1_valid_ff;
   logic [1:0]     s1_op_ff;
   logic [7:0]     s1_code_ff;
   logic           rsp_valid_ff;
   logic [1:0]     rsp_status_ff;
   logic [7:0]     rsp_mods_ff;
   logic [7:0]     rsp_keys_ff [SLOT_MAX];
   logic [7:0]     held_mods_ff;
   logic [7:0]     held_keys_ff [SLOT_MAX];

   logic [7:0]     held_mods_in;
   logic [7:0]     held_keys_in [SLOT_MAX];
   status_type     status_in;
   key_decode_type decoded;
   logic           present;
   logic           placed;
   logic           s1_advance;

   hidkb_key_decoder u_decoder (
      .key_code (s1_code_ff),
      .decoded  (decoded)
   );

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;

   always_comb begin
      held_mods_in = held_mods_ff;
      held_keys_in = held_keys_ff;
      status_in    = ST_SENT;
      present      = 1'b0;
      placed       = 1'b0;
      if (s1_op_ff[1]) begin
         held_mods_in = '0;
         for (int i = 0; i < SLOT_MAX; i++) begin
            held_keys_in[i] = '0;
         end
      end else if (!decoded.mapped) begin
         status_in = ST_UNMAPPED;
      end else begin
         case (s1_op_ff)
            OP_PRESS: begin
               held_mods_in = held_mods_ff | decoded.mods;
               for (int i = 0; i < SLOT_MAX; i++) begin
                  if (i < KEY_SLOTS && held_keys_ff[i] == decoded.usage) begin
                     present = 1'b1;
                  end
               end
               if (!present) begin
                  for (int i = 0; i < SLOT_MAX; i++) begin
                     if (!placed && i < KEY_SLOTS && held_keys_ff[i] == 8'd0) begin
                        held_keys_in[i] = decoded.usage;
                        placed = 1'b1;
                     end
                  end
                  if (!placed) begin
                     status_in = ST_FULL;
                  end
               end
            end
            default: begin
               held_mods_in = held_mods_ff & ~decoded.mods;
               if (decoded.usage != 8'd0) begin
                  for (int i = 0; i < SLOT_MAX; i++) begin
                     if (i < KEY_SLOTS && held_keys_ff[i] == decoded.usage) begin
                        held_keys_in[i] = '0;
                     end
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         held_mods_ff <= '0;
         for (int i = 0; i < SLOT_MAX; i++) begin
            held_keys_ff[i] <= '0;
         end
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s1_advance) begin
            rsp_valid_ff <= 1'b1;
            held_mods_ff <= held_mods_in;
            held_keys_ff <= held_keys_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_op_ff   <= req_operation;
         s1_code_ff <= req_key_code;
      end
      if (s1_advance) begin
         rsp_status_ff <= status_in;
         rsp_mods_ff   <= held_mods_in;
         rsp_keys_ff   <= held_keys_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_modifier_byte = rsp_mods_ff;
   assign rsp_slot_zero     = rsp_keys_ff[0];
   assign rsp_slot_one      = rsp_keys_ff[1];
   assign rsp_slot_two      = rsp_keys_ff[2];
   assign rsp_slot_three    = rsp_keys_ff[3];
   assign rsp_slot_four     = rsp_keys_ff[4];
   assign rsp_slot_five     = rsp_keys_ff[5];

endmodule
